FILE: design/sto_pkg.sv
// ----------------------------------------------------------------------------
// sto_pkg
// Shared types and constants of the sorted timeout queue.
// ----------------------------------------------------------------------------
package sto_pkg;

    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_EXP  = 2'd1;
    localparam logic [1:0] EV_ARM  = 2'd2;
    localparam logic [1:0] EV_REJ  = 2'd3;

    localparam logic [31:0] GUARD_RESET = 32'hFFFF_F000;

    typedef struct packed {
        logic [1:0] ev;
        logic [3:0] id;
        logic       last;
    } t_res;

endpackage

FILE: design/sto_ram.sv
// ----------------------------------------------------------------------------
// sto_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module sto_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/sto_outreg.sv
// ----------------------------------------------------------------------------
// sto_outreg
// Output register of the result stream.
// ----------------------------------------------------------------------------
module sto_outreg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  sto_pkg::t_res i_res,
    output logic          o_ok,
    output logic          o_valid,
    input  logic          i_ready,
    output sto_pkg::t_res o_res
);
    import sto_pkg::*;

    logic r_valid;
    t_res r_res;

    assign o_ok = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

FILE: design/sto_ctrl.sv
// ----------------------------------------------------------------------------
// sto_ctrl
// Sequencer: walks the sorted list in memory to insert and expire timers.
// ----------------------------------------------------------------------------
module sto_ctrl #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_mode,
    input  logic [3:0]                    i_slot_sel,
    input  logic [31:0]                   i_delay,
    input  logic                          i_cfg_valid,
    input  logic [31:0]                   i_cfg_data,
    output logic                          o_dl_we,
    output logic [$clog2(NUM_TIMERS)-1:0] o_dl_waddr,
    output logic [31:0]                   o_dl_wdata,
    output logic                          o_nx_we,
    output logic [$clog2(NUM_TIMERS)-1:0] o_nx_waddr,
    output logic [$clog2(NUM_TIMERS+1)-1:0] o_nx_wdata,
    output logic [$clog2(NUM_TIMERS)-1:0] o_raddr,
    input  logic [31:0]                   i_dl_rdata,
    input  logic [$clog2(NUM_TIMERS+1)-1:0] i_nx_rdata,
    input  logic                          i_out_ok,
    output logic                          o_out_load,
    output sto_pkg::t_res                 o_out_res
);
    import sto_pkg::*;

    localparam int SW = $clog2(NUM_TIMERS);
    localparam int PW = $clog2(NUM_TIMERS + 1);
    localparam logic [PW-1:0] LIST_END = PW'(NUM_TIMERS);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_C_CHK  = 11'b000_0000_0010,
        S_C_WR   = 11'b000_0000_0100,
        S_C_RD   = 11'b000_0000_1000,
        S_C_CMP  = 11'b000_0001_0000,
        S_C_LINK = 11'b000_0010_0000,
        S_C_FIX  = 11'b000_0100_0000,
        S_FIN    = 11'b000_1000_0000,
        S_T_INC  = 11'b001_0000_0000,
        S_T_RD   = 11'b010_0000_0000,
        S_T_CMP  = 11'b100_0000_0000
    } t_state;

    t_state          r_state, n_state;
    logic            r_mode;
    logic [3:0]      r_id;
    logic [31:0]     r_delay;
    logic [31:0]     r_cnt, n_cnt;
    logic [31:0]     r_base, n_base;
    logic [31:0]     r_thr;
    logic [31:0]     r_new, n_new;
    logic [PW-1:0]   r_cur, n_cur;
    logic [PW-1:0]   r_prev, n_prev;
    logic [PW-1:0]   r_head, n_head;
    logic [NUM_TIMERS-1:0] r_armed, n_armed;
    logic            r_pend_v, n_pend_v;
    logic [PW-1:0]   r_pend_id, n_pend_id;
    t_res            r_fin, n_fin;

    logic            in_acc;
    logic            id_bad;
    logic [32:0]     sum;
    logic [31:0]     rd_true;
    logic [SW-1:0]   slot;

    assign in_acc  = i_in_valid && o_in_ready;
    assign id_bad  = ({28'd0, r_id} >= 32'(NUM_TIMERS));
    assign sum     = {1'b0, r_delay} + {1'b0, r_cnt};
    assign rd_true = i_dl_rdata - r_base;
    assign slot    = SW'(r_id);

    assign o_in_ready = (r_state == S_IDLE);
    assign o_raddr    = r_mode ? r_cur[SW-1:0] : r_head[SW-1:0];
    assign o_dl_waddr = slot;
    assign o_dl_wdata = r_new + r_base;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_base     = r_base;
        n_new      = r_new;
        n_cur      = r_cur;
        n_prev     = r_prev;
        n_head     = r_head;
        n_armed    = r_armed;
        n_pend_v   = r_pend_v;
        n_pend_id  = r_pend_id;
        n_fin      = r_fin;
        o_dl_we    = 1'b0;
        o_nx_we    = 1'b0;
        o_nx_waddr = slot;
        o_nx_wdata = r_cur;
        o_out_load = 1'b0;
        o_out_res  = r_fin;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = i_mode ? S_C_CHK : S_T_INC;
                end
            end
            S_C_CHK: begin
                if (id_bad || r_armed[slot]) begin
                    n_fin   = '{ev: EV_REJ, id: r_id, last: 1'b1};
                    n_state = S_FIN;
                end else begin
                    if (sum[32]) begin
                        n_base = r_base + r_cnt;
                        n_cnt  = '0;
                        n_new  = r_delay;
                    end else begin
                        n_new  = sum[31:0];
                    end
                    n_state = S_C_WR;
                end
            end
            S_C_WR: begin
                o_dl_we = 1'b1;
                n_cur   = r_head;
                n_prev  = LIST_END;
                n_state = S_C_RD;
            end
            S_C_RD: begin
                n_state = (r_cur == LIST_END) ? S_C_LINK : S_C_CMP;
            end
            S_C_CMP: begin
                if (rd_true < r_new) begin
                    n_prev  = r_cur;
                    n_cur   = i_nx_rdata;
                    n_state = S_C_RD;
                end else begin
                    n_state = S_C_LINK;
                end
            end
            S_C_LINK: begin
                o_nx_we       = 1'b1;
                n_armed[slot] = 1'b1;
                n_fin         = '{ev: EV_ARM, id: r_id, last: 1'b1};
                if (r_prev == LIST_END) begin
                    n_head  = PW'(r_id);
                    n_state = S_FIN;
                end else begin
                    n_state = S_C_FIX;
                end
            end
            S_C_FIX: begin
                o_nx_we    = 1'b1;
                o_nx_waddr = r_prev[SW-1:0];
                o_nx_wdata = PW'(r_id);
                n_state    = S_FIN;
            end
            S_FIN: begin
                if (i_out_ok) begin
                    o_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_T_INC: begin
                n_cnt    = r_cnt + 32'd1;
                n_pend_v = 1'b0;
                n_state  = S_T_RD;
            end
            S_T_RD, S_T_CMP: begin
                if (r_state == S_T_CMP && r_head != LIST_END && rd_true <= r_cnt) begin
                    if (!r_pend_v || i_out_ok) begin
                        o_out_load = r_pend_v;
                        o_out_res  = '{ev: EV_EXP, id: 4'(r_pend_id), last: 1'b0};
                        n_pend_v   = 1'b1;
                        n_pend_id  = r_head;
                        n_head     = i_nx_rdata;
                        n_armed[r_head[SW-1:0]] = 1'b0;
                        n_state    = S_T_RD;
                    end
                end else if (r_state == S_T_RD && r_head != LIST_END) begin
                    n_state = S_T_CMP;
                end else begin
                    if (r_cnt >= r_thr) begin
                        n_base = r_base + r_cnt;
                        n_cnt  = '0;
                    end
                    n_fin   = r_pend_v ? '{ev: EV_EXP, id: 4'(r_pend_id), last: 1'b1}
                                       : '{ev: EV_NONE, id: 4'd0, last: 1'b1};
                    n_state = S_FIN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_base   <= '0;
            r_thr    <= GUARD_RESET;
            r_head   <= LIST_END;
            r_armed  <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_base   <= n_base;
            r_head   <= n_head;
            r_armed  <= n_armed;
            r_pend_v <= n_pend_v;
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode  <= i_mode;
            r_id    <= i_slot_sel;
            r_delay <= i_delay;
        end
        r_new     <= n_new;
        r_cur     <= n_cur;
        r_prev    <= n_prev;
        r_pend_id <= n_pend_id;
        r_fin     <= n_fin;
    end

endmodule

FILE: design/sorted_timeout_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_timeout_queue_top
// Tick counter with one-shot timers kept in a deadline-sorted linked list.
// ----------------------------------------------------------------------------
// One item is processed at a time; the next beat is accepted only in idle.
// An arm checks the slot, writes the deadline, then reads and compares each
// list entry with an earlier deadline before it links the new entry; a
// rejected arm goes straight to its result. A tick steps the counter, then
// reads and compares the head and unlinks each expired timer, one result
// beat per expiry. A full result register stalls the sequencer. The walk
// reads the deadline and link memories. No clearing pass runs after reset.
module sorted_timeout_queue_top #(
    parameter int NUM_TIMERS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // slot_sel[3:0], delay[35:4], zero fill
    input  logic [0:0]  i_s_axis_tuser,   // mode[0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // timer_id[3:0], zero fill
    output logic [1:0]  o_m_axis_tuser,   // event_res[1:0]
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);
    import sto_pkg::*;

    localparam int SW = $clog2(NUM_TIMERS);
    localparam int PW = $clog2(NUM_TIMERS + 1);

    logic          dl_we, nx_we;
    logic [SW-1:0] dl_waddr, nx_waddr, raddr;
    logic [31:0]   dl_wdata, dl_rdata;
    logic [PW-1:0] nx_wdata, nx_rdata;
    logic          out_ok, out_load;
    t_res          out_res, m_res;

    assign o_cfg_ready = 1'b1;

    sto_ctrl #(.NUM_TIMERS(NUM_TIMERS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_mode     (i_s_axis_tuser[0]),
        .i_slot_sel (i_s_axis_tdata[3:0]),
        .i_delay    (i_s_axis_tdata[35:4]),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_dl_we    (dl_we),
        .o_dl_waddr (dl_waddr),
        .o_dl_wdata (dl_wdata),
        .o_nx_we    (nx_we),
        .o_nx_waddr (nx_waddr),
        .o_nx_wdata (nx_wdata),
        .o_raddr    (raddr),
        .i_dl_rdata (dl_rdata),
        .i_nx_rdata (nx_rdata),
        .i_out_ok   (out_ok),
        .o_out_load (out_load),
        .o_out_res  (out_res)
    );

    sto_ram #(.WIDTH(32), .DEPTH(NUM_TIMERS)) u_dl_ram (
        .i_clk  (i_clk),
        .i_we   (dl_we),
        .i_waddr(dl_waddr),
        .i_wdata(dl_wdata),
        .i_raddr(raddr),
        .o_rdata(dl_rdata)
    );

    sto_ram #(.WIDTH(PW), .DEPTH(NUM_TIMERS)) u_nx_ram (
        .i_clk  (i_clk),
        .i_we   (nx_we),
        .i_waddr(nx_waddr),
        .i_wdata(nx_wdata),
        .i_raddr(raddr),
        .o_rdata(nx_rdata)
    );

    sto_outreg u_outreg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (out_load),
        .i_res  (out_res),
        .o_ok   (out_ok),
        .o_valid(o_m_axis_tvalid),
        .i_ready(i_m_axis_tready),
        .o_res  (m_res)
    );

    assign o_m_axis_tdata = {4'd0, m_res.id};
    assign o_m_axis_tuser = m_res.ev;
    assign o_m_axis_tlast = m_res.last;

endmodule

FILE: design/sto_chk.sv
// ----------------------------------------------------------------------------
// sto_chk
// Port-level checks of the sorted timeout queue, bound to the top level.
// ----------------------------------------------------------------------------
module sto_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic [1:0] o_m_axis_tuser,
    input logic       o_m_axis_tlast
);
    import sto_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        ($stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("result payload changed while stalled");

    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == EV_NONE) |->
        (o_m_axis_tlast && o_m_axis_tdata == 8'd0))
        else $error("idle tick beat malformed");

    a_create_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == EV_ARM || o_m_axis_tuser == EV_REJ))
        |-> o_m_axis_tlast)
        else $error("create result not marked last");

endmodule

bind sorted_timeout_queue_top sto_chk u_sto_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata),
    .o_m_axis_tuser (o_m_axis_tuser),
    .o_m_axis_tlast (o_m_axis_tlast)
);

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted timeout queue: random arm and tick beats
// with random source gaps and sink stalls, predicted timer list, per-field
// compare of every result beat against the oldest predicted beat.
// ----------------------------------------------------------------------------
module tb;
    import sto_pkg::*;

    localparam int NT = 16;
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_ARM  = 1'b1;

    typedef struct {
        logic        mode;
        logic [3:0]  id;
        logic [31:0] delay;
    } t_cmd;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;

    t_cmd        cmd_q[$];
    t_res        exp_q[$];
    int          errors = 0;
    int          n_beats = 0;
    int          n_expired = 0;
    int          src_wait = 0;
    int          snk_wait = 0;
    int          hold_cycles = 0;
    bit          src_pause = 1'b0;

    // predictor state
    logic [31:0] guard;
    logic [31:0] ticks;
    logic [31:0] dl[NT];
    bit          armed[NT];
    int          nxt[NT];
    int          head;

    sorted_timeout_queue_top u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tuser(m_tuser), .o_m_axis_tlast(m_tlast),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic t_res mk(logic [1:0] ev, logic [3:0] id, logic lst);
        t_res r;
        r.ev = ev;
        r.id = id;
        r.last = lst;
        return r;
    endfunction

    function automatic void rebase_deadlines();
        for (int i = 0; i < NT; i++)
            if (armed[i]) dl[i] -= ticks;
        ticks = '0;
    endfunction

    function automatic void predict_timers(t_cmd c);
        logic [31:0] sum;
        int prv, cur, k;
        if (c.mode == MODE_ARM) begin
            if (armed[c.id]) begin
                exp_q.push_back(mk(EV_REJ, c.id, 1'b1));
                return;
            end
            sum = c.delay + ticks;
            if (sum < c.delay) begin
                rebase_deadlines();
                sum = c.delay;
            end
            dl[c.id] = sum;
            armed[c.id] = 1'b1;
            prv = NT;
            cur = head;
            while (cur < NT && dl[cur] < sum) begin
                prv = cur;
                cur = nxt[cur];
            end
            nxt[c.id] = cur;
            if (prv == NT) head = c.id;
            else nxt[prv] = c.id;
            exp_q.push_back(mk(EV_ARM, c.id, 1'b1));
            return;
        end
        ticks++;
        k = 0;
        while (head < NT && dl[head] <= ticks) begin
            armed[head] = 1'b0;
            exp_q.push_back(mk(EV_EXP, head[3:0], 1'b0));
            head = nxt[head];
            k++;
        end
        if (ticks >= guard) rebase_deadlines();
        if (k == 0) exp_q.push_back(mk(EV_NONE, 4'd0, 1'b1));
        else exp_q[$].last = 1'b1;
    endfunction

    // source side
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                predict_timers(cmd_q.pop_front());
                n_beats++;
                src_wait <= $urandom_range(0, 3);
                s_tvalid <= 1'b0;
            end else if (!s_tvalid && !src_pause && cmd_q.size() > 0) begin
                if (src_wait > 0) begin
                    src_wait <= src_wait - 1;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= cmd_q[0].mode;
                    s_tdata  <= {4'b0, cmd_q[0].delay, cmd_q[0].id};
                end
            end
        end
    end

    // sink side
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                if (exp_q.size() == 0) begin
                    $display("%0t: unexpected beat ev=%0d id=%0d last=%0b",
                             $time, m_tuser, m_tdata[3:0], m_tlast);
                    errors++;
                end else begin
                    t_res e;
                    e = exp_q.pop_front();
                    if (e.ev == EV_EXP) n_expired++;
                    if (m_tuser !== e.ev) begin
                        $display("%0t: event exp %0d got %0d", $time, e.ev, m_tuser);
                        errors++;
                    end
                    if (m_tdata !== {4'b0, e.id}) begin
                        $display("%0t: id exp %0d got %0d", $time, e.id, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== e.last) begin
                        $display("%0t: last exp %0b got %0b", $time, e.last, m_tlast);
                        errors++;
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_tready <= 1'b0;
            end else if (snk_wait > 0) begin
                snk_wait <= snk_wait - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (m_tvalid && m_tready) snk_wait <= $urandom_range(0, 3);
            end
        end
    end

    task automatic add_cmd(logic mode, logic [3:0] id, logic [31:0] delay);
        t_cmd c;
        c.mode = mode;
        c.id = id;
        c.delay = delay;
        cmd_q.push_back(c);
    endtask

    task automatic drain();
        while (cmd_q.size() > 0 || s_tvalid || exp_q.size() > 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_guard(logic [31:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        guard = v;
    endtask

    task automatic random_phase(int n, int dmax);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 9);
            if (r < 5) add_cmd(MODE_TICK, 4'($urandom), $urandom);
            else if (r < 9) add_cmd(MODE_ARM, 4'($urandom), $urandom_range(0, dmax));
            else add_cmd(MODE_ARM, 4'($urandom), $urandom);
        end
    endtask

    initial begin
        guard = GUARD_RESET;
        ticks = '0;
        head = NT;
        for (int i = 0; i < NT; i++) begin
            armed[i] = 1'b0;
            dl[i] = '0;
            nxt[i] = NT;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, zero delay, equal deadlines, reject, idle tick
        src_pause = 1'b1;
        add_cmd(MODE_TICK, 4'hF, 32'hFFFF_FFFF);
        add_cmd(MODE_ARM, 4'd0, 32'd0);
        add_cmd(MODE_ARM, 4'd0, 32'd5);
        add_cmd(MODE_ARM, 4'd15, 32'd2);
        add_cmd(MODE_ARM, 4'd7, 32'd2);
        add_cmd(MODE_ARM, 4'd3, 32'hFFFF_FFFF);
        add_cmd(MODE_ARM, 4'd9, 32'hFFFF_FFF0);
        add_cmd(MODE_ARM, 4'd10, 32'hAAAA_5555);
        for (int i = 0; i < 4; i++) add_cmd(MODE_TICK, 4'd0, 32'd0);
        // fill the sink while the source keeps offering
        hold_cycles = 300;
        src_pause = 1'b0;
        drain();

        set_guard(32'd0);
        add_cmd(MODE_ARM, 4'd1, 32'd3);
        add_cmd(MODE_ARM, 4'd2, 32'd1);
        random_phase(50, 6);
        drain();

        set_guard(32'd20);
        random_phase(80, 12);
        drain();

        set_guard(32'hFFFF_FFFF);
        random_phase(60, 8);
        drain();

        set_guard(GUARD_RESET);
        random_phase(60, 10);
        drain();

        $display("tb: %0d input beats, %0d timer expiries, guard values 0 to max",
                 n_beats, n_expired);
        if (errors == 0) $display("tb: clean");
        else $display("tb: errors");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: errors");
        $finish;
    end
endmodule

FILE: filelist.f
design/sto_pkg.sv
design/sto_ram.sv
design/sto_outreg.sv
design/sto_ctrl.sv
design/sorted_timeout_queue_top.sv
design/sto_chk.sv
test/tb.sv
